@@ design/framed_target_servo_slew_controller_top_macros.svh @@
`ifndef FRAMED_TARGET_SERVO_SLEW_CONTROLLER_TOP_MACROS_SVH
`define FRAMED_TARGET_SERVO_SLEW_CONTROLLER_TOP_MACROS_SVH

// Concurrent check that is switched off while reset is high.
`define FSSC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also holds across reset.
`define FSSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/fssc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fssc_pkg;

   // Full-scale angle in degrees.
   localparam int ANGLE_FULL_DEF = 180;

   // Frame header bytes.
   localparam logic [7:0] HDR1_BYTE = 8'hAA;
   localparam logic [7:0] HDR2_BYTE = 8'h55;

   // State after reset.
   localparam logic [7:0] ANGLE_RESET = 8'd90;
   localparam logic [7:0] ID_RESET    = 8'd0;

   // Event codes carried by the mode field.
   localparam logic [1:0] MODE_BYTE     = 2'd0;
   localparam logic [1:0] MODE_TICK     = 2'd1;
   localparam logic [1:0] MODE_LINE_ERR = 2'd2;

   // Register port geometry.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Register indexes, one word apart.
   typedef enum logic [2:0] {
      REG_PAN_DZ,
      REG_TILT_DZ,
      REG_PAN_STEP,
      REG_TILT_STEP,
      REG_PAN_REV,
      REG_PULSE_ZERO,
      REG_PULSE_FULL
   } csr_reg_type;

   // Register reset values.
   localparam logic [7:0]  PAN_DZ_RESET     = 8'd2;
   localparam logic [7:0]  TILT_DZ_RESET    = 8'd2;
   localparam logic [7:0]  PAN_STEP_RESET   = 8'd10;
   localparam logic [7:0]  TILT_STEP_RESET  = 8'd6;
   localparam logic        PAN_REV_RESET    = 1'b1;
   localparam logic [15:0] PULSE_ZERO_RESET = 16'd500;
   localparam logic [15:0] PULSE_FULL_RESET = 16'd2500;

   typedef struct packed {
      logic [7:0]  pan_dz;
      logic [7:0]  tilt_dz;
      logic [7:0]  pan_step;
      logic [7:0]  tilt_step;
      logic        pan_rev;
      logic [15:0] pulse_zero;
      logic [15:0] pulse_full;
   } cfg_type;

   // Decoded event strobes for an accepted beat.
   typedef struct packed {
      logic byte_beat;
      logic tick_beat;
      logic line_err;
   } evt_type;

   // Result fields that travel down the pulse pipeline unchanged.
   typedef struct packed {
      logic       drive_valid;
      logic [7:0] pan_position;
      logic [7:0] tilt_position;
      logic [7:0] frame_tag;
      logic       frame_accepted;
      logic       frame_rejected;
   } info_type;

endpackage

`default_nettype wire

@@ design/fssc_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Input channel: one event per beat.
interface fssc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [7:0] rx_data;

   modport source (output valid, mode, rx_data, input ready);
   modport sink   (input valid, mode, rx_data, output ready);
endinterface

// Result channel: one result per beat.
interface fssc_rsp_if;
   logic        valid;
   logic        ready;
   logic        drive_valid;
   logic [15:0] pan_pulse;
   logic [15:0] tilt_pulse;
   logic [7:0]  pan_position;
   logic [7:0]  tilt_position;
   logic [7:0]  frame_tag;
   logic        frame_accepted;
   logic        frame_rejected;

   modport source (output valid, drive_valid, pan_pulse, tilt_pulse, pan_position,
                   tilt_position, frame_tag, frame_accepted, frame_rejected,
                   input ready);
   modport sink   (input valid, drive_valid, pan_pulse, tilt_pulse, pan_position,
                   tilt_position, frame_tag, frame_accepted, frame_rejected,
                   output ready);
endinterface

`default_nettype wire

@@ design/fssc_csr.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fssc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [fssc_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [fssc_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [fssc_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready,
   output fssc_pkg::cfg_type                cfg
);
   import fssc_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] reg_index;
   logic       write_en;

   assign reg_index = paddr[CSR_ADDR_W-1:2];
   assign write_en  = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign cfg       = cfg_ff;

   // Register write decode; writes beyond the list are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (reg_index)
            REG_PAN_DZ:     cfg_in.pan_dz     = pwdata[7:0];
            REG_TILT_DZ:    cfg_in.tilt_dz    = pwdata[7:0];
            REG_PAN_STEP:   cfg_in.pan_step   = pwdata[7:0];
            REG_TILT_STEP:  cfg_in.tilt_step  = pwdata[7:0];
            REG_PAN_REV:    cfg_in.pan_rev    = pwdata[0];
            REG_PULSE_ZERO: cfg_in.pulse_zero = pwdata[15:0];
            REG_PULSE_FULL: cfg_in.pulse_full = pwdata[15:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   // Read mux.
   always_comb begin
      case (reg_index)
         REG_PAN_DZ:     prdata = {24'd0, cfg_ff.pan_dz};
         REG_TILT_DZ:    prdata = {24'd0, cfg_ff.tilt_dz};
         REG_PAN_STEP:   prdata = {24'd0, cfg_ff.pan_step};
         REG_TILT_STEP:  prdata = {24'd0, cfg_ff.tilt_step};
         REG_PAN_REV:    prdata = {31'd0, cfg_ff.pan_rev};
         REG_PULSE_ZERO: prdata = {16'd0, cfg_ff.pulse_zero};
         REG_PULSE_FULL: prdata = {16'd0, cfg_ff.pulse_full};
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pan_dz     <= PAN_DZ_RESET;
         cfg_ff.tilt_dz    <= TILT_DZ_RESET;
         cfg_ff.pan_step   <= PAN_STEP_RESET;
         cfg_ff.tilt_step  <= TILT_STEP_RESET;
         cfg_ff.pan_rev    <= PAN_REV_RESET;
         cfg_ff.pulse_zero <= PULSE_ZERO_RESET;
         cfg_ff.pulse_full <= PULSE_FULL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

@@ design/fssc_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fssc_parser (
   input  logic              clock,
   input  logic              reset,
   input  fssc_pkg::evt_type evt,
   input  logic [7:0]        rx_data,
   output logic [7:0]        aim_pan,
   output logic [7:0]        aim_tilt,
   output logic [7:0]        id_next,
   output logic              frame_accepted,
   output logic              frame_rejected
);
   import fssc_pkg::*;

   typedef enum logic [2:0] {
      PH_HDR1,
      PH_HDR2,
      PH_PAN,
      PH_TILT,
      PH_ID,
      PH_CHK
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] stg_pan_ff, stg_pan_in;
   logic [7:0] stg_tilt_ff, stg_tilt_in;
   logic [7:0] stg_id_ff, stg_id_in;
   logic [7:0] tgt_pan_ff, tgt_pan_in;
   logic [7:0] tgt_tilt_ff, tgt_tilt_in;
   logic [7:0] tgt_id_ff, tgt_id_in;
   logic [7:0] check_sum;

   // Frame parser. A line error only returns the parser to header wait.
   always_comb begin
      phase_in       = phase_ff;
      stg_pan_in     = stg_pan_ff;
      stg_tilt_in    = stg_tilt_ff;
      stg_id_in      = stg_id_ff;
      tgt_pan_in     = tgt_pan_ff;
      tgt_tilt_in    = tgt_tilt_ff;
      tgt_id_in      = tgt_id_ff;
      frame_accepted = 1'b0;
      frame_rejected = 1'b0;
      check_sum      = stg_pan_ff + stg_tilt_ff + stg_id_ff;
      if (evt.line_err) begin
         phase_in = PH_HDR1;
      end else if (evt.byte_beat) begin
         case (phase_ff)
            PH_HDR2: begin
               if (rx_data == HDR2_BYTE) begin
                  phase_in = PH_PAN;
               end else if (rx_data == HDR1_BYTE) begin
                  phase_in = PH_HDR2;
               end else begin
                  phase_in = PH_HDR1;
               end
            end
            PH_PAN: begin
               stg_pan_in = rx_data;
               phase_in   = PH_TILT;
            end
            PH_TILT: begin
               stg_tilt_in = rx_data;
               phase_in    = PH_ID;
            end
            PH_ID: begin
               stg_id_in = rx_data;
               phase_in  = PH_CHK;
            end
            PH_CHK: begin
               if (rx_data == check_sum) begin
                  tgt_pan_in     = stg_pan_ff;
                  tgt_tilt_in    = stg_tilt_ff;
                  tgt_id_in      = stg_id_ff;
                  frame_accepted = 1'b1;
               end else begin
                  frame_rejected = 1'b1;
               end
               phase_in = PH_HDR1;
            end
            default: begin
               phase_in = (rx_data == HDR1_BYTE) ? PH_HDR2 : PH_HDR1;
            end
         endcase
      end
   end

   assign aim_pan  = tgt_pan_ff;
   assign aim_tilt = tgt_tilt_ff;
   assign id_next  = tgt_id_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HDR1;
         stg_pan_ff  <= ANGLE_RESET;
         stg_tilt_ff <= ANGLE_RESET;
         stg_id_ff   <= ID_RESET;
         tgt_pan_ff  <= ANGLE_RESET;
         tgt_tilt_ff <= ANGLE_RESET;
         tgt_id_ff   <= ID_RESET;
      end else begin
         phase_ff    <= phase_in;
         stg_pan_ff  <= stg_pan_in;
         stg_tilt_ff <= stg_tilt_in;
         stg_id_ff   <= stg_id_in;
         tgt_pan_ff  <= tgt_pan_in;
         tgt_tilt_ff <= tgt_tilt_in;
         tgt_id_ff   <= tgt_id_in;
      end
   end

endmodule

`default_nettype wire

@@ design/fssc_axis.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fssc_axis #(
   parameter int ANGLE_FULL = fssc_pkg::ANGLE_FULL_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              tick,
   input  logic signed [9:0] target,
   input  logic [7:0]        dead_zone,
   input  logic [7:0]        max_step,
   output logic [7:0]        position_next
);
   import fssc_pkg::*;

   localparam logic signed [10:0] FULL_S = 11'(ANGLE_FULL);

   logic [7:0]         pos_ff, pos_in;
   logic signed [9:0]  diff;
   logic signed [9:0]  dz;
   logic signed [9:0]  st;
   logic signed [9:0]  step_up;
   logic signed [9:0]  step_dn;
   logic signed [10:0] moved;

   // Slew toward the target outside the dead zone, then clamp to range.
   always_comb begin
      dz      = $signed({2'b00, dead_zone});
      st      = $signed({2'b00, max_step});
      diff    = target - $signed({2'b00, pos_ff});
      step_up = (diff > st) ? st : diff;
      step_dn = (-diff > st) ? st : -diff;
      moved   = $signed({3'b000, pos_ff});
      if (diff > dz) begin
         moved = $signed({3'b000, pos_ff}) + {step_up[9], step_up};
      end else if (diff < -dz) begin
         moved = $signed({3'b000, pos_ff}) - {step_dn[9], step_dn};
      end
      if (moved > FULL_S) begin
         moved = FULL_S;
      end else if (moved < 11'sd0) begin
         moved = 11'sd0;
      end
      pos_in = tick ? moved[7:0] : pos_ff;
   end

   assign position_next = pos_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= ANGLE_RESET;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

`default_nettype wire

@@ design/fssc_pipe.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fssc_pipe #(
   parameter int ANGLE_FULL = fssc_pkg::ANGLE_FULL_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  fssc_pkg::info_type in_info,
   input  fssc_pkg::cfg_type  cfg,
   output logic               out_valid,
   input  logic               out_ready,
   output fssc_pkg::info_type out_info,
   output logic [15:0]        out_pan_pulse,
   output logic [15:0]        out_tilt_pulse
);
   import fssc_pkg::*;

   // Angle times span fits 24 bits for any full-scale angle below 256.
   localparam int X_W         = 24;
   localparam int RECIP_SHIFT = 24;
   localparam int RECIP_W     = 25;
   localparam int PROD_W      = X_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_MULT = RECIP_W'((2 ** RECIP_SHIFT) / ANGLE_FULL);
   localparam logic [X_W-1:0]     DIVISOR    = X_W'(ANGLE_FULL);
   localparam logic [7:0]         FULL_ANGLE = 8'(ANGLE_FULL);

   // The reciprocal quotient is low by at most one; one compare fixes it.
   function automatic logic [15:0] correct_quot(input logic [X_W-1:0] x,
                                                input logic [15:0] q0);
      logic [X_W-1:0] rem;
      rem = x - {8'd0, q0} * DIVISOR;
      return (rem >= DIVISOR) ? q0 + 16'd1 : q0;
   endfunction

   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in, v4_ff, v4_in;
   logic en1, en2, en3, en4;

   info_type         s1_info_ff, s2_info_ff, s3_info_ff, s4_info_ff;
   logic [X_W-1:0]   s2_xp_ff, s2_xp_in, s2_xt_ff, s2_xt_in;
   logic [X_W-1:0]   s3_xp_ff, s3_xt_ff;
   logic [15:0]      s3_qp_ff, s3_qp_in, s3_qt_ff, s3_qt_in;
   logic [15:0]      s4_pp_ff, s4_pp_in, s4_pt_ff, s4_pt_in;
   logic [15:0]      span;
   logic [7:0]       ang_p, ang_t;
   logic [PROD_W-1:0] prod_p, prod_t;

   // Each stage loads when it is empty or its content moves on.
   assign en4      = !v4_ff || out_ready;
   assign en3      = !v3_ff || en4;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   assign v1_in = en1 ? in_valid : v1_ff;
   assign v2_in = en2 ? v1_ff : v2_ff;
   assign v3_in = en3 ? v2_ff : v3_ff;
   assign v4_in = en4 ? v3_ff : v4_ff;

   // Stage two: clamped angle times span.
   always_comb begin
      span     = (cfg.pulse_full >= cfg.pulse_zero) ? cfg.pulse_full - cfg.pulse_zero : 16'd0;
      ang_p    = (s1_info_ff.pan_position > FULL_ANGLE) ? FULL_ANGLE : s1_info_ff.pan_position;
      ang_t    = (s1_info_ff.tilt_position > FULL_ANGLE) ? FULL_ANGLE : s1_info_ff.tilt_position;
      s2_xp_in = {16'd0, ang_p} * {8'd0, span};
      s2_xt_in = {16'd0, ang_t} * {8'd0, span};
   end

   // Stage three: multiply by the reciprocal of the full-scale angle.
   always_comb begin
      prod_p   = {{RECIP_W{1'b0}}, s2_xp_ff} * {{X_W{1'b0}}, RECIP_MULT};
      prod_t   = {{RECIP_W{1'b0}}, s2_xt_ff} * {{X_W{1'b0}}, RECIP_MULT};
      s3_qp_in = prod_p[RECIP_SHIFT +: 16];
      s3_qt_in = prod_t[RECIP_SHIFT +: 16];
   end

   // Stage four: quotient correction and pulse offset.
   always_comb begin
      s4_pp_in = cfg.pulse_zero + correct_quot(s3_xp_ff, s3_qp_ff);
      s4_pt_in = cfg.pulse_zero + correct_quot(s3_xt_ff, s3_qt_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (en1) begin
         s1_info_ff <= in_info;
      end
      if (en2) begin
         s2_info_ff <= s1_info_ff;
         s2_xp_ff   <= s2_xp_in;
         s2_xt_ff   <= s2_xt_in;
      end
      if (en3) begin
         s3_info_ff <= s2_info_ff;
         s3_xp_ff   <= s2_xp_ff;
         s3_xt_ff   <= s2_xt_ff;
         s3_qp_ff   <= s3_qp_in;
         s3_qt_ff   <= s3_qt_in;
      end
      if (en4) begin
         s4_info_ff <= s3_info_ff;
         s4_pp_ff   <= s4_pp_in;
         s4_pt_ff   <= s4_pt_in;
      end
   end

   assign out_valid      = v4_ff;
   assign out_info       = s4_info_ff;
   assign out_pan_pulse  = s4_pp_ff;
   assign out_tilt_pulse = s4_pt_ff;

endmodule

`default_nettype wire

@@ design/framed_target_servo_slew_controller_top.sv @@
// Throughput: one event per cycle unless a stalled result side fills the pipe;
// parser, target and angle registers update in the accept cycle, and the
// pulse conversion is a four-stage elastic pipe (angle times span,
// reciprocal multiply, remainder correction and offset).
// Reset (synchronous): parser waits for a header, targets 90/90/id 0, angles 90,
// registers to their defaults, pipeline emptied.
`timescale 1ns / 1ps
`default_nettype none

module framed_target_servo_slew_controller_top #(
   parameter int ANGLE_FULL = fssc_pkg::ANGLE_FULL_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   fssc_req_if.sink                         req_bus,
   fssc_rsp_if.source                       rsp_bus,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [fssc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [fssc_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [fssc_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import fssc_pkg::*;

   localparam logic signed [9:0] FULL_T = 10'(ANGLE_FULL);

   cfg_type           cfg;
   evt_type           evt;
   info_type          in_info, out_info;
   logic              accept, in_ready;
   logic [7:0]        tgt_pan, tgt_tilt, id_next;
   logic              frame_acc, frame_rej;
   logic signed [9:0] pan_tgt, tilt_tgt;
   logic [7:0]        pan_next, tilt_next;

   fssc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // Event decode of the accepted beat; unused mode codes raise no event strobe.
   assign accept        = req_bus.valid && in_ready;
   assign req_bus.ready = in_ready;
   assign evt.byte_beat = accept && (req_bus.mode == MODE_BYTE);
   assign evt.tick_beat = accept && (req_bus.mode == MODE_TICK);
   assign evt.line_err  = accept && (req_bus.mode == MODE_LINE_ERR);

   fssc_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .evt            (evt),
      .rx_data        (req_bus.rx_data),
      .aim_pan        (tgt_pan),
      .aim_tilt       (tgt_tilt),
      .id_next        (id_next),
      .frame_accepted (frame_acc),
      .frame_rejected (frame_rej)
   );

   // Pan target, mirrored about full scale when reversed.
   assign pan_tgt  = cfg.pan_rev ? FULL_T - $signed({2'b00, tgt_pan}) : $signed({2'b00, tgt_pan});
   assign tilt_tgt = $signed({2'b00, tgt_tilt});

   fssc_axis #(.ANGLE_FULL(ANGLE_FULL)) u_pan_axis (
      .clock         (clock),
      .reset         (reset),
      .tick          (evt.tick_beat),
      .target        (pan_tgt),
      .dead_zone     (cfg.pan_dz),
      .max_step      (cfg.pan_step),
      .position_next (pan_next)
   );

   fssc_axis #(.ANGLE_FULL(ANGLE_FULL)) u_tilt_axis (
      .clock         (clock),
      .reset         (reset),
      .tick          (evt.tick_beat),
      .target        (tilt_tgt),
      .dead_zone     (cfg.tilt_dz),
      .max_step      (cfg.tilt_step),
      .position_next (tilt_next)
   );

   assign in_info.drive_valid    = evt.tick_beat;
   assign in_info.pan_position   = pan_next;
   assign in_info.tilt_position  = tilt_next;
   assign in_info.frame_tag      = id_next;
   assign in_info.frame_accepted = frame_acc;
   assign in_info.frame_rejected = frame_rej;

   fssc_pipe #(.ANGLE_FULL(ANGLE_FULL)) u_pipe (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_bus.valid),
      .in_ready       (in_ready),
      .in_info        (in_info),
      .cfg            (cfg),
      .out_valid      (rsp_bus.valid),
      .out_ready      (rsp_bus.ready),
      .out_info       (out_info),
      .out_pan_pulse  (rsp_bus.pan_pulse),
      .out_tilt_pulse (rsp_bus.tilt_pulse)
   );

   assign rsp_bus.drive_valid    = out_info.drive_valid;
   assign rsp_bus.pan_position   = out_info.pan_position;
   assign rsp_bus.tilt_position  = out_info.tilt_position;
   assign rsp_bus.frame_tag      = out_info.frame_tag;
   assign rsp_bus.frame_accepted = out_info.frame_accepted;
   assign rsp_bus.frame_rejected = out_info.frame_rejected;

endmodule

`default_nettype wire

@@ design/fssc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "framed_target_servo_slew_controller_top_macros.svh"

module fssc_checker #(
   parameter int ANGLE_FULL = fssc_pkg::ANGLE_FULL_DEF
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_drive_valid,
   input logic [15:0] rsp_pan_pulse,
   input logic [15:0] rsp_tilt_pulse,
   input logic [7:0]  rsp_pan_position,
   input logic [7:0]  rsp_tilt_position,
   input logic [7:0]  rsp_frame_tag,
   input logic        rsp_frame_accepted,
   input logic        rsp_frame_rejected
);

   // A stalled result beat holds.
   `FSSC_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive_valid)
         && $stable(rsp_pan_pulse) && $stable(rsp_tilt_pulse)
         && $stable(rsp_pan_position) && $stable(rsp_tilt_position)
         && $stable(rsp_frame_tag) && $stable(rsp_frame_accepted)
         && $stable(rsp_frame_rejected),
      "result beat changed while stalled")

   // Frame flags come only from a checksum byte, never from a tick.
   `FSSC_ASSERT(a_flags_exclusive, clock, reset,
      rsp_valid |-> !(rsp_frame_accepted && rsp_frame_rejected)
         && !(rsp_drive_valid && (rsp_frame_accepted || rsp_frame_rejected)),
      "frame flags clash")

   // A tick leaves both axes inside the angle range.
   `FSSC_ASSERT(a_tick_in_range, clock, reset,
      rsp_valid && rsp_drive_valid |-> (rsp_pan_position <= 8'(ANGLE_FULL))
         && (rsp_tilt_position <= 8'(ANGLE_FULL)),
      "position out of range after tick")

   // Reset empties the result register.
   `FSSC_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind framed_target_servo_slew_controller_top fssc_checker #(.ANGLE_FULL(ANGLE_FULL)) u_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_drive_valid    (rsp_bus.drive_valid),
   .rsp_pan_pulse      (rsp_bus.pan_pulse),
   .rsp_tilt_pulse     (rsp_bus.tilt_pulse),
   .rsp_pan_position   (rsp_bus.pan_position),
   .rsp_tilt_position  (rsp_bus.tilt_position),
   .rsp_frame_tag      (rsp_bus.frame_tag),
   .rsp_frame_accepted (rsp_bus.frame_accepted),
   .rsp_frame_rejected (rsp_bus.frame_rejected)
);

`default_nettype wire
